// File: hdl/pcw_pkg.sv
`default_nettype none

package pcw_pkg;

  // Wheel geometry
  localparam int WheelCycle = 768;
  localparam int KeysMax    = 8;
  localparam int PaletteMax = 8;

  localparam int PosW  = 16;
  localparam int PW    = 10;  // position within one wheel cycle, 0..767
  localparam int PalW  = 4;
  localparam int SegW  = 3;
  localparam int CntW  = 4;
  localparam int ChanW = 8;
  localparam int ColW  = 24;

  // Palette codes
  localparam logic [PalW-1:0] PAL_RAINBOW = 4'd0;
  localparam logic [PalW-1:0] PAL_OCEAN   = 4'd1;
  localparam logic [PalW-1:0] PAL_FIRE    = 4'd2;
  localparam logic [PalW-1:0] PAL_PLASMA  = 4'd3;
  localparam logic [PalW-1:0] PAL_VIRIDIS = 4'd4;
  localparam logic [PalW-1:0] PAL_SUNSET  = 4'd5;
  localparam logic [PalW-1:0] PAL_ARCTIC  = 4'd6;
  localparam logic [PalW-1:0] PAL_EARTH   = 4'd7;
  localparam logic [PalW-1:0] PAL_NEON    = 4'd8;
  localparam logic [PalW-1:0] PAL_LAST    = PAL_NEON;
  localparam logic [PalW-1:0] PAL_RESET   = PAL_SUNSET;

  // Key colors, packed {r, g, b}; unused slots are zero
  localparam logic [ColW-1:0] KEYS [0:PaletteMax][0:KeysMax-1] = '{
    '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{24'h000050, 24'h003296, 24'h0096C8, 24'h32C8FF, 24'h96E6FF, 24'hC8F5FF,
      24'h0, 24'h0},
    '{24'h000000, 24'h500000, 24'h960000, 24'hFF3200, 24'hFF9600, 24'hFFFF64,
      24'hFFFFFF, 24'h0},
    '{24'h500050, 24'h780078, 24'hB40096, 24'hDC3264, 24'hFF6432, 24'hFFB400,
      24'hFFFF64, 24'h0},
    '{24'h460050, 24'h32328C, 24'h1E64B4, 24'h0082A0, 24'h28A078, 24'h78C850,
      24'hC8DC32, 24'h0},
    '{24'h001450, 24'h140064, 24'h500078, 24'h963264, 24'hC86432, 24'hFF9600,
      24'hFFC832, 24'h0},
    '{24'h003264, 24'h326496, 24'h6496C8, 24'hB4DCFF, 24'hE6FAFF, 24'hC8FFFF,
      24'h0, 24'h0},
    '{24'h643200, 24'h966432, 24'h649632, 24'h32C864, 24'h009696, 24'h0064C8,
      24'h3232FF, 24'h0},
    '{24'hFF00FF, 24'hFF0080, 24'hFF3200, 24'hFFFF00, 24'h00FF00, 24'h00FFFF,
      24'h0000FF, 24'h8000FF}
  };

  // Number of key colors in a palette
  function automatic logic [CntW-1:0] key_count(input logic [PalW-1:0] pal);
    logic [CntW-1:0] n;
    case (pal)
      PAL_RAINBOW: n = 4'd3;
      PAL_OCEAN:   n = 4'd6;
      PAL_ARCTIC:  n = 4'd6;
      PAL_NEON:    n = 4'd8;
      default:     n = 4'd7;
    endcase
    return n;
  endfunction

  // Key color lookup; codes beyond the last palette fall back to the reset one
  function automatic logic [ColW-1:0] key_color(input logic [PalW-1:0] pal,
                                                input logic [SegW-1:0] idx);
    logic [PalW-1:0] p;
    p = (pal > PAL_LAST) ? PAL_RESET : pal;
    return KEYS[p][idx];
  endfunction

endpackage

`default_nettype wire

// File: hdl/pcw_blend.sv
`default_nettype none

// One color channel: c1 + floor(rem * (c2 - c1) / 768), three register stages.
module pcw_blend (
  input  wire logic                       clk,
  input  wire logic [pcw_pkg::ChanW-1:0]  c1,
  input  wire logic [pcw_pkg::ChanW-1:0]  c2,
  input  wire logic [pcw_pkg::PW-1:0]     rem,
  output      logic [pcw_pkg::ChanW-1:0]  chan
);
  import pcw_pkg::*;

  localparam int ProdW = PW + ChanW;
  localparam int QW    = PW + 11;
  localparam logic [ProdW-1:0] RoundUp = ProdW'(WheelCycle - 1);

  // stage A: sign and magnitude of the difference
  logic [ChanW-1:0] a_c1, a_mag;
  logic             a_neg;
  logic [PW-1:0]    a_rem;
  // stage B: product
  logic [ChanW-1:0] b_c1;
  logic             b_neg;
  logic [ProdW-1:0] b_prod;
  // stage C: rounded and divided by 256
  logic [ChanW-1:0] c_c1;
  logic             c_neg;
  logic [PW-1:0]    c_hi;

  logic [ProdW-1:0] t;
  logic [QW-1:0]    quo;

  assign t = b_prod + (b_neg ? RoundUp : '0);

  always_ff @(posedge clk) begin
    a_neg  <= c2 < c1;
    a_mag  <= (c2 < c1) ? (c1 - c2) : (c2 - c1);
    a_c1   <= c1;
    a_rem  <= rem;

    b_prod <= ProdW'(a_rem) * ProdW'(a_mag);
    b_c1   <= a_c1;
    b_neg  <= a_neg;

    c_hi   <= t[ProdW-1:8];
    c_c1   <= b_c1;
    c_neg  <= b_neg;
  end

  // divide by 3: x*683 >> 11 is exact for x < 2048
  assign quo  = QW'(c_hi) * QW'(683);
  assign chan = c_neg ? (c_c1 - quo[11 +: ChanW]) : (c_c1 + quo[11 +: ChanW]);

endmodule

`default_nettype wire

// File: hdl/palette_color_wheel.sv
`default_nettype none

// Palette color wheel: maps a 16-bit wheel position (taken modulo 768) to a
// packed GRB color {green, red, blue} blended between the key colors of the
// palette chosen by cfg_wdata (written with cfg_we; codes above 8 are ignored;
// sunset after reset). Throughput is one transaction per clock: start is taken
// on any cycle in which busy is low, and busy is high only during reset and for
// the first cycle after it. Each color appears on grb_color with a one-cycle
// done strobe once its start has passed through the six-stage pipeline
// (position fold, segment split, difference, multiply, round, divide and add).
// The receiver cannot stall, so results must be captured on the done cycle.
// The palette is sampled with the position, so items in flight keep the
// palette they entered with.
module palette_color_wheel (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic [pcw_pkg::PosW-1:0]    wheel_position,
  input  wire logic                        cfg_we,
  input  wire logic [pcw_pkg::PalW-1:0]    cfg_wdata,
  output      logic                        done,
  output      logic [pcw_pkg::ColW-1:0]    grb_color
);
  import pcw_pkg::*;

  localparam int Depth = 4;  // valid stages from s2 through blend stage C

  logic [PalW-1:0] palette;

  // stage 1
  logic            v1;
  logic [PW-1:0]   s1_p;
  logic [PalW-1:0] s1_pal;
  // stage 2
  logic [Depth-1:0] vpipe;
  logic [SegW-1:0]  s2_seg, s2_nxt;
  logic [PW-1:0]    s2_rem;
  logic [PalW-1:0]  s2_pal;

  logic             accept;
  logic [15:0]      hi_prod;
  logic [6:0]       hi_div;
  logic [7:0]       hi_mod;
  logic [CntW-1:0]  n1;
  logic [12:0]      q;
  logic [4:0]       qh;
  logic [9:0]       qh_prod;
  logic [SegW-1:0]  seg;
  logic [4:0]       rem_hi;
  logic [CntW-1:0]  seg_inc;
  logic [ColW-1:0]  key_a, key_b;
  logic [ChanW-1:0] ch_r, ch_g, ch_b;

  assign accept = start && !busy;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      palette <= PAL_RESET;
    end else if (cfg_we && cfg_wdata <= PAL_LAST) begin
      palette <= cfg_wdata;
    end
  end

  // position mod 768: upper byte mod 3 (x*171 >> 9 is x/3 for x < 512)
  assign hi_prod = 16'(wheel_position[15:8]) * 16'd171;
  assign hi_div  = hi_prod[15:9];
  assign hi_mod  = wheel_position[15:8] - 8'(hi_div) * 8'd3;

  // segment split: q = p*n, seg = q/768, rem = q%768 (x*11 >> 5 is x/3 for x < 32)
  assign n1      = key_count(s1_pal);
  assign q       = 13'(s1_p) * 13'(n1);
  assign qh      = q[12:8];
  assign qh_prod = 10'(qh) * 10'd11;
  assign seg     = qh_prod[7:5];
  assign rem_hi  = qh - 5'(seg) * 5'd3;
  assign seg_inc = CntW'(seg) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      vpipe <= '0;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      v1    <= accept;
      vpipe <= {vpipe[Depth-2:0], v1};
      busy  <= 1'b0;
      done  <= vpipe[Depth-1];
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    s1_p   <= {hi_mod[1:0], wheel_position[7:0]};
    s1_pal <= palette;

    s2_seg <= seg;
    s2_nxt <= (seg_inc == n1) ? '0 : seg_inc[SegW-1:0];
    s2_rem <= {rem_hi[1:0], q[7:0]};
    s2_pal <= s1_pal;

    grb_color <= {ch_g, ch_r, ch_b};
  end

  // key colors of the segment ends
  assign key_a = key_color(s2_pal, s2_seg);
  assign key_b = key_color(s2_pal, s2_nxt);

  pcw_blend u_red (
    .clk  (clk),
    .c1   (key_a[23:16]),
    .c2   (key_b[23:16]),
    .rem  (s2_rem),
    .chan (ch_r)
  );

  pcw_blend u_green (
    .clk  (clk),
    .c1   (key_a[15:8]),
    .c2   (key_b[15:8]),
    .rem  (s2_rem),
    .chan (ch_g)
  );

  pcw_blend u_blue (
    .clk  (clk),
    .c1   (key_a[7:0]),
    .c2   (key_b[7:0]),
    .rem  (s2_rem),
    .chan (ch_b)
  );

endmodule

`default_nettype wire

// File: hdl/pcw_checker.sv
`default_nettype none

// Port-level checks on the color wheel.
module pcw_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic [pcw_pkg::PosW-1:0]    wheel_position,
  input wire logic                        cfg_we,
  input wire logic [pcw_pkg::PalW-1:0]    cfg_wdata,
  input wire logic                        done,
  input wire logic [pcw_pkg::ColW-1:0]    grb_color
);

  // every accepted transaction yields a strobe once it leaves the pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##6 done)
    else $error("missing done after accepted transaction");

  // no strobe without a matching transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##6 !done)
    else $error("done without accepted transaction");

  // reset drops the strobe and raises busy
  a_reset_done: assert property (@(posedge clk)
    rst |=> !done && busy)
    else $error("reset did not clear done or set busy");

  // busy only follows reset
  a_busy_free: assert property (@(posedge clk)
    !rst |=> !busy)
    else $error("busy raised outside reset");

endmodule

bind palette_color_wheel pcw_checker u_pcw_checker (.*);

`default_nettype wire

// File: tb/tb_palette_color_wheel.sv
`default_nettype none

module tb_palette_color_wheel;
  timeunit 1ns;
  timeprecision 1ps;

  import pcw_pkg::*;

  localparam int IdleLimit  = 500;
  localparam int DrainWait  = 8;
  localparam int RandPhases = 16;

  // Tracks the active palette and the colors still due from the pipeline
  class color_ledger;
    bit [ColW-1:0]   key_rgb [PaletteMax+1][KeysMax];
    int unsigned     key_num [PaletteMax+1];
    logic [PalW-1:0] palette;
    logic [ColW-1:0] due_colors [$];
    int              mismatches;

    function new();
      // key colors as {r, g, b}, unused slots zero
      key_rgb = '{
        '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h000000,
          24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{24'h000050, 24'h003296, 24'h0096C8, 24'h32C8FF,
          24'h96E6FF, 24'hC8F5FF, 24'h000000, 24'h000000},
        '{24'h000000, 24'h500000, 24'h960000, 24'hFF3200,
          24'hFF9600, 24'hFFFF64, 24'hFFFFFF, 24'h000000},
        '{24'h500050, 24'h780078, 24'hB40096, 24'hDC3264,
          24'hFF6432, 24'hFFB400, 24'hFFFF64, 24'h000000},
        '{24'h460050, 24'h32328C, 24'h1E64B4, 24'h0082A0,
          24'h28A078, 24'h78C850, 24'hC8DC32, 24'h000000},
        '{24'h001450, 24'h140064, 24'h500078, 24'h963264,
          24'hC86432, 24'hFF9600, 24'hFFC832, 24'h000000},
        '{24'h003264, 24'h326496, 24'h6496C8, 24'hB4DCFF,
          24'hE6FAFF, 24'hC8FFFF, 24'h000000, 24'h000000},
        '{24'h643200, 24'h966432, 24'h649632, 24'h32C864,
          24'h009696, 24'h0064C8, 24'h3232FF, 24'h000000},
        '{24'hFF00FF, 24'hFF0080, 24'hFF3200, 24'hFFFF00,
          24'h00FF00, 24'h00FFFF, 24'h0000FF, 24'h8000FF}
      };
      key_num    = '{3, 6, 7, 7, 7, 7, 6, 7, 8};
      palette    = PAL_SUNSET;
      mismatches = 0;
    endfunction

    // c1 + floor(rem*(c2-c1)/768), floor toward minus infinity
    function int mix_channel(int c1, int c2, int rem);
      int prod;
      prod = rem * (c2 - c1);
      if (prod >= 0) return c1 + prod / WheelCycle;
      return c1 - (WheelCycle - 1 - prod) / WheelCycle;
    endfunction

    // codes above the last palette leave the register alone
    function void write_palette(logic [PalW-1:0] code);
      if (code <= PAL_LAST) palette = code;
    endfunction

    // predict the color for one accepted position
    function void note_position(logic [PosW-1:0] pos);
      int unsigned     n, p, q, seg, rem, nxt;
      bit [ColW-1:0]   lo, hi;
      logic [ChanW-1:0] r, g, b;
      n   = key_num[palette];
      p   = pos % WheelCycle;
      q   = p * n;
      seg = q / WheelCycle;
      rem = q % WheelCycle;
      nxt = (seg + 1) % n;
      lo  = key_rgb[palette][seg];
      hi  = key_rgb[palette][nxt];
      r   = ChanW'(mix_channel(lo[23:16], hi[23:16], rem));
      g   = ChanW'(mix_channel(lo[15:8], hi[15:8], rem));
      b   = ChanW'(mix_channel(lo[7:0], hi[7:0], rem));
      due_colors.push_back({g, r, b});
    endfunction

    function void check_color(logic [ColW-1:0] actual);
      logic [ColW-1:0] want;
      if (due_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected color %06h", actual);
      end else begin
        want = due_colors.pop_front();
        if (actual !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("grb_color mismatch: expected %06h actual %06h", want, actual);
        end
      end
    endfunction

    function int pending();
      return due_colors.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [PosW-1:0]  wheel_position = '0;
  logic             cfg_we = 1'b0;
  logic [PalW-1:0]  cfg_wdata = '0;
  logic             done;
  logic [ColW-1:0]  grb_color;

  color_ledger ledger = new();
  int          idle_cycles = 0;
  int          burst_left = 0;

  palette_color_wheel i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .wheel_position (wheel_position),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .done           (done),
    .grb_color      (grb_color)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Monitor: transactions, palette writes, results and the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) ledger.note_position(wheel_position);
      if (cfg_we) ledger.write_palette(cfg_wdata);
      if (done) ledger.check_color(grb_color);
    end
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // start stays high across back-to-back transactions
  task automatic send_position(input logic [PosW-1:0] pos, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    wheel_position <= pos;
    do @(posedge clk); while (busy);
  endtask

  // wait until the pipeline has handed back everything
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic load_palette(input logic [PalW-1:0] code);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random gap, with occasional back-to-back bursts
  function automatic int draw_gap();
    if (burst_left == 0 && $urandom_range(0, 7) == 0) burst_left = $urandom_range(20, 60);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  // mostly uniform positions, the rest near key boundaries
  function automatic logic [PosW-1:0] draw_position();
    int unsigned step, p;
    if ($urandom_range(0, 9) < 6) return PosW'($urandom_range(0, (1 << PosW) - 1));
    step = WheelCycle / $urandom_range(3, 8);
    p    = (step * $urandom_range(0, 8) + $urandom_range(0, 2) + WheelCycle - 1) % WheelCycle;
    return PosW'($urandom_range(0, 84) * WheelCycle + p);
  endfunction

  initial begin
    logic [PosW-1:0] sunset_pos [10];
    logic [PosW-1:0] rainbow_pos [5];
    logic [PosW-1:0] neon_pos [4];
    logic [PalW-1:0] all_pals [PaletteMax+1];
    logic [PalW-1:0] code;
    int              count;

    sunset_pos  = '{16'd0, 16'd1, 16'd767, 16'd768, 16'hFFFF, 16'd110, 16'd109,
                    16'd383, 16'hAAAA, 16'h5555};
    rainbow_pos = '{16'd255, 16'd256, 16'd511, 16'd512, 16'd767};
    neon_pos    = '{16'd0, 16'd96, 16'd671, 16'hFFFF};
    all_pals    = '{PAL_RAINBOW, PAL_OCEAN, PAL_FIRE, PAL_PLASMA, PAL_VIRIDIS,
                    PAL_SUNSET, PAL_ARCTIC, PAL_EARTH, PAL_NEON};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: reset palette, rainbow thirds, ignored codes, neon wrap
    foreach (sunset_pos[i]) send_position(sunset_pos[i], draw_gap());
    load_palette(PAL_RAINBOW);
    foreach (rainbow_pos[i]) send_position(rainbow_pos[i], draw_gap());
    load_palette(PalW'(PAL_LAST + 1));
    load_palette(PalW'((1 << PalW) - 1));
    send_position(16'd256, draw_gap());
    send_position(16'd600, draw_gap());
    load_palette(PAL_NEON);
    foreach (neon_pos[i]) send_position(neon_pos[i], draw_gap());

    // random phases: every palette in turn, then random codes
    for (int ph = 0; ph < RandPhases; ph++) begin
      if (ph <= PaletteMax) code = all_pals[ph];
      else if ($urandom_range(0, 4) == 0)
        code = PalW'($urandom_range(PAL_LAST + 1, (1 << PalW) - 1));
      else code = all_pals[$urandom_range(0, PaletteMax)];
      load_palette(code);
      count = $urandom_range(25, 55);
      repeat (count) send_position(draw_position(), draw_gap());
    end

    settle();
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: palette_color_wheel.f
hdl/pcw_pkg.sv
hdl/pcw_blend.sv
hdl/palette_color_wheel.sv
hdl/pcw_checker.sv
tb/tb_palette_color_wheel.sv
